[sv/vw3_pkg.sv]
// Shared types and constants of the 3D DDA voxel walker.
package vw3_pkg;

	localparam logic [2:0] REG_SIZE_X  = 3'd0;
	localparam logic [2:0] REG_SIZE_Y  = 3'd1;
	localparam logic [2:0] REG_SIZE_Z  = 3'd2;
	localparam logic [2:0] REG_DELTA_X = 3'd3;
	localparam logic [2:0] REG_DELTA_Y = 3'd4;
	localparam logic [2:0] REG_DELTA_Z = 3'd5;

	localparam logic [4:0]  SIZE_RST  = 5'd16;
	localparam logic [30:0] DELTA_RST = 31'd8738;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [31:0] NEVER       = 32'hFFFF_FFFF;
	localparam logic [30:0] EXIT_SAT    = 31'h7FFF_FFFF;
	localparam logic [5:0]  MAX_RESULTS = 6'd48;

	typedef struct packed {
		logic [2:0][30:0] rel;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic [2:0]       zero;
		logic [30:0]      limit;
	} ray_t;

	typedef struct packed {
		logic [2:0][4:0]  size_m1;
		logic [2:0][30:0] delta;
	} cfg_t;

endpackage

[sv/voxel_walk_3d_dda.sv]
// Top level of the 3D DDA voxel walker: register port, intake and walk engine.
//
//  channel | signals                                   | moves
//  in      | in_valid/in_ready, rel_*, dir_*, max_dist | one ray request
//  out     | out_valid/out_ready, cell_*, stepped_axis,| one visited voxel
//          | exit_param, last                          |
//  apb     | psel/penable/pwrite/paddr/pwdata/prdata   | register write/read
//
// Setup per ray: after the accept, per axis a start-index search by repeated subtraction
// and, for a nonzero direction, two divides (first crossing, increment) on the
// shared one-bit-a-cycle divider.
// The walk then emits one voxel per cycle while out_ready holds high.
// Up to two rays queue ahead of the walk engine; in_ready drops when both are held.
// Reset clears all control state and returns the registers to their defaults.
module voxel_walk_3d_dda #(
	parameter int CELLS_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] rel_x,
	input  logic [30:0] rel_y,
	input  logic [30:0] rel_z,
	input  logic [31:0] dir_x,
	input  logic [31:0] dir_y,
	input  logic [31:0] dir_z,
	input  logic [30:0] max_dist,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  cell_x,
	output logic [3:0]  cell_y,
	output logic [3:0]  cell_z,
	output logic [1:0]  stepped_axis,
	output logic [30:0] exit_param,
	output logic        last
);

	localparam logic [4:0] CMAX = 5'(CELLS_MAX);

	logic [4:0]    size_q [3];
	logic [30:0]   delta_q [3];
	logic [2:0]    idx;
	logic          wr;
	vw3_pkg::cfg_t cfg;
	logic [30:0]   rel [3];
	logic [31:0]   dir [3];
	logic          q_valid;
	logic          q_ready;
	vw3_pkg::ray_t q_ray;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				size_q[k]  <= vw3_pkg::SIZE_RST;
				delta_q[k] <= vw3_pkg::DELTA_RST;
			end
		end else if (wr) begin
			unique case (idx)
				vw3_pkg::REG_SIZE_X:  size_q[0]  <= pwdata[4:0];
				vw3_pkg::REG_SIZE_Y:  size_q[1]  <= pwdata[4:0];
				vw3_pkg::REG_SIZE_Z:  size_q[2]  <= pwdata[4:0];
				vw3_pkg::REG_DELTA_X: delta_q[0] <= pwdata[30:0];
				vw3_pkg::REG_DELTA_Y: delta_q[1] <= pwdata[30:0];
				vw3_pkg::REG_DELTA_Z: delta_q[2] <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			vw3_pkg::REG_SIZE_X:  prdata = {27'd0, size_q[0]};
			vw3_pkg::REG_SIZE_Y:  prdata = {27'd0, size_q[1]};
			vw3_pkg::REG_SIZE_Z:  prdata = {27'd0, size_q[2]};
			vw3_pkg::REG_DELTA_X: prdata = {1'b0, delta_q[0]};
			vw3_pkg::REG_DELTA_Y: prdata = {1'b0, delta_q[1]};
			vw3_pkg::REG_DELTA_Z: prdata = {1'b0, delta_q[2]};
			default:              prdata = 32'd0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			priority if (size_q[k] < 5'd2) begin
				cfg.size_m1[k] = 5'd1;
			end else if (size_q[k] > CMAX) begin
				cfg.size_m1[k] = CMAX - 5'd1;
			end else begin
				cfg.size_m1[k] = size_q[k] - 5'd1;
			end
			cfg.delta[k] = delta_q[k];
		end
	end

	assign rel[0] = rel_x;
	assign rel[1] = rel_y;
	assign rel[2] = rel_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	vw3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rel      (rel),
		.dir      (dir),
		.max_dist (max_dist),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_ray    (q_ray)
	);

	vw3_back #(
		.CELLS_MAX (CELLS_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_ray        (q_ray),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.cell_z       (cell_z),
		.stepped_axis (stepped_axis),
		.exit_param   (exit_param),
		.last         (last)
	);

endmodule

[sv/vw3_front.sv]
// Request intake: sign and magnitude split of the direction, and a two-entry queue.
module vw3_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [30:0]      rel [3],
	input  logic [31:0]      dir [3],
	input  logic [30:0]      max_dist,
	output logic             q_valid,
	input  logic             q_ready,
	output vw3_pkg::ray_t    q_ray
);

	vw3_pkg::ray_t ray_in;
	vw3_pkg::ray_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ray_in.rel[k]  = rel[k];
			ray_in.neg[k]  = dir[k][31];
			ray_in.zero[k] = (dir[k] == 32'd0);
			ray_in.mag[k]  = dir[k][31] ? (32'd0 - dir[k]) : dir[k];
		end
		ray_in.limit = max_dist;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_ray    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= ray_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[sv/vw3_div.sv]
// Radix-2 restoring divider for (dividend << 16) / divisor, saturated to 32 bits.
module vw3_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dvd,
	input  logic [31:0] dvs,
	output logic        done,
	output logic        busy,
	output logic [31:0] quo
);

	logic        busy_q;
	logic        fin_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] sh_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	logic        sat;

	assign trial = {rem_q, sh_q[31]};
	assign ge    = (trial >= {1'b0, dvs});
	assign diff  = trial - {1'b0, dvs};
	assign sat   = ({17'd0, dvd} >= {dvs, 16'd0});
	assign done  = fin_q;
	assign busy  = busy_q;
	assign quo   = sh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {17'd0, dvd[30:16]};
			sh_q  <= sat ? vw3_pkg::NEVER : {dvd[15:0], 16'd0};
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			sh_q  <= {sh_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				fin_q  <= sat;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

endmodule

[sv/vw3_back.sv]
// Ray setup sequencer and voxel walk with the result register.
module vw3_back #(
	parameter int CELLS_MAX = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vw3_pkg::cfg_t cfg,
	input  logic          q_valid,
	output logic          q_ready,
	input  vw3_pkg::ray_t q_ray,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    cell_x,
	output logic [3:0]    cell_y,
	output logic [3:0]    cell_z,
	output logic [1:0]    stepped_axis,
	output logic [30:0]   exit_param,
	output logic          last
);

	localparam int IDX_W = $clog2(CELLS_MAX);
	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CELL  = 5'b00010,
		S_DIV1  = 5'b00100,
		S_DIV2  = 5'b01000,
		S_WALK  = 5'b10000
	} state_t;

	state_t            state_q;
	vw3_pkg::ray_t     ray_q;
	logic [1:0]        ax_q;
	logic [IDX_W-1:0]  cx_q;
	logic [30:0]       rem_q;
	logic [IDX_W-1:0]  cidx_q [3];
	logic [31:0]       ncr_q [3];
	logic [31:0]       inc_q [3];
	logic [5:0]        cnt_q;
	logic              out_valid_q;
	logic [3:0]        cell_q [3];
	logic [1:0]        axis_q;
	logic [30:0]       exit_q;
	logic              last_q;

	logic [30:0]       del_c [3];
	logic [30:0]       cur_del;
	logic [4:0]        cur_sm1;
	logic              cell_more;
	logic [30:0]       first_dist;
	logic              div_start;
	logic              div_done;
	logic              div_busy;
	logic [31:0]       div_quo;
	logic [30:0]       dvd;
	logic              axis_done;

	logic [1:0]        sel;
	logic [31:0]       t;
	logic              emit;
	logic [IDX_W-1:0]  cur;
	logic [IDX_W:0]    up;
	logic [5:0]        up_ext;
	logic              leave;
	logic              fin;
	logic [32:0]       sum;
	logic [IDX_W-1:0]  nidx;
	logic [IDX_W+3:0]  ext [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			del_c[k] = (cfg.delta[k] == 31'd0) ? 31'd1 : cfg.delta[k];
		end
	end

	assign cur_del   = del_c[ax_q];
	assign cur_sm1   = cfg.size_m1[ax_q];
	assign cell_more = (6'(cx_q) < {1'b0, cur_sm1}) && (rem_q >= cur_del);
	assign first_dist = ray_q.neg[ax_q] ? rem_q :
		((rem_q >= cur_del) ? 31'd0 : (cur_del - rem_q));
	assign dvd       = (state_q == S_CELL) ? first_dist : cur_del;
	assign div_start = ((state_q == S_CELL) && !cell_more && !ray_q.zero[ax_q]) ||
		((state_q == S_DIV1) && div_done);
	assign axis_done = ((state_q == S_CELL) && !cell_more && ray_q.zero[ax_q]) ||
		((state_q == S_DIV2) && div_done);
	assign q_ready   = (state_q == S_IDLE);

	vw3_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (dvd),
		.dvs    (ray_q.mag[ax_q]),
		.done   (div_done),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_comb begin
		priority if (ncr_q[0] < ncr_q[1] && ncr_q[0] < ncr_q[2]) begin
			sel = vw3_pkg::AXIS_X;
		end else if (ncr_q[1] < ncr_q[2]) begin
			sel = vw3_pkg::AXIS_Y;
		end else begin
			sel = vw3_pkg::AXIS_Z;
		end
	end

	assign t      = ncr_q[sel];
	assign emit   = (state_q == S_WALK) && (!out_valid_q || out_ready);
	assign cur    = cidx_q[sel];
	assign up     = {1'b0, cur} + {{IDX_W{1'b0}}, 1'b1};
	assign up_ext = 6'(up);
	assign leave  = ray_q.zero[sel] ? 1'b0 :
		(ray_q.neg[sel] ? (cur == '0) : (up_ext >= {1'b0, cfg.size_m1[sel]}));
	assign fin    = (t > {1'b0, ray_q.limit}) || leave ||
		(cnt_q == vw3_pkg::MAX_RESULTS - 6'd1);
	assign sum    = {1'b0, t} + {1'b0, inc_q[sel]};
	assign nidx   = ray_q.zero[sel] ? cur : (ray_q.neg[sel] ? (cur - IDX_ONE) : up[IDX_W-1:0]);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ext[k] = {4'd0, cidx_q[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			ray_q <= q_ray;
			cx_q  <= '0;
			rem_q <= q_ray.rel[0];
		end else if (state_q == S_CELL && cell_more) begin
			cx_q  <= cx_q + IDX_ONE;
			rem_q <= rem_q - cur_del;
		end else if (axis_done && ax_q != vw3_pkg::AXIS_Z) begin
			cx_q  <= '0;
			rem_q <= ray_q.rel[ax_q + 2'd1];
		end
		if (state_q == S_CELL && !cell_more) begin
			cidx_q[ax_q] <= cx_q;
			if (ray_q.zero[ax_q]) begin
				ncr_q[ax_q] <= vw3_pkg::NEVER;
				inc_q[ax_q] <= 32'd0;
			end
		end
		if (state_q == S_DIV1 && div_done) begin
			ncr_q[ax_q] <= div_quo;
		end
		if (state_q == S_DIV2 && div_done) begin
			inc_q[ax_q] <= div_quo;
		end
		if (emit) begin
			for (int k = 0; k < 3; k++) begin
				cell_q[k] <= ext[k][3:0];
			end
			axis_q <= sel;
			exit_q <= t[31] ? vw3_pkg::EXIT_SAT : t[30:0];
			last_q <= fin;
			cidx_q[sel] <= nidx;
			if (!fin) begin
				ncr_q[sel] <= sum[32] ? vw3_pkg::NEVER : sum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= vw3_pkg::AXIS_X;
			cnt_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_CELL;
						ax_q    <= vw3_pkg::AXIS_X;
					end
				end
				S_CELL: begin
					if (axis_done) begin
						if (ax_q == vw3_pkg::AXIS_Z) begin
							state_q <= S_WALK;
							cnt_q   <= 6'd0;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else if (div_start) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						if (ax_q == vw3_pkg::AXIS_Z) begin
							state_q <= S_WALK;
							cnt_q   <= 6'd0;
						end else begin
							state_q <= S_CELL;
							ax_q    <= ax_q + 2'd1;
						end
					end
				end
				S_WALK: begin
					if (emit) begin
						cnt_q <= cnt_q + 6'd1;
						if (fin) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_x       = cell_q[0];
	assign cell_y       = cell_q[1];
	assign cell_z       = cell_q[2];
	assign stepped_axis = axis_q;
	assign exit_param   = exit_q;
	assign last         = last_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider busy outside a divide state");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q < vw3_pkg::MAX_RESULTS))
		else $error("walk ran past the result bound");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && fin) |=> (state_q == S_IDLE))
		else $error("walk continued after its final voxel");

endmodule

[verif/tb_top.sv]
// Self-checking testbench of voxel_walk_3d_dda: directed and random rays checked by a walk predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0][30:0] rel;
		logic [2:0][31:0] dir;
		logic [30:0]      maxd;
	} ray_req_t;

	typedef struct packed {
		logic [3:0]  cx;
		logic [3:0]  cy;
		logic [3:0]  cz;
		logic [1:0]  axis;
		logic [30:0] exit_t;
		logic        fin;
	} voxel_t;

	typedef struct packed {
		ray_req_t ray;
		logic     known;
		voxel_t   want;
	} ray_row_t;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [30:0] rel_x = '0, rel_y = '0, rel_z = '0, max_dist = '0;
	logic [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] cell_x, cell_y, cell_z;
	logic [1:0] stepped_axis;
	logic [30:0] exit_param;
	logic last;

	logic [2:0][4:0]  grid_size;
	logic [2:0][30:0] voxel_edge;
	voxel_t voxel_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int rx_cyc = 0;
	int burst_left = 4;
	ray_row_t rows[$];

	voxel_walk_3d_dda dut (.*);

	always #4 clk = ~clk;

	function automatic longint unsigned sat_u32(longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic void trace_ray(ray_req_t r);
		longint unsigned sz, del, relv, dv, mag, cx, face, t;
		longint unsigned nxt[3], inc[3];
		longint signed idx[3], stp[3], ext[3];
		int ax, n;
		bit leave, done;
		voxel_t v;
		for (int i = 0; i < 3; i++) begin
			sz = grid_size[i] < 2 ? 2 : (grid_size[i] > 16 ? 16 : grid_size[i]);
			del = voxel_edge[i] == 0 ? 1 : voxel_edge[i];
			relv = r.rel[i];
			dv = r.dir[i];
			cx = relv / del;
			if (cx >= sz)
				cx = sz - 1;
			idx[i] = cx;
			if (dv == 0) begin
				stp[i] = 0;
				ext[i] = -1;
				inc[i] = 0;
				nxt[i] = 64'hFFFF_FFFF;
			end else begin
				if (dv[31]) begin
					mag = 64'h1_0000_0000 - dv;
					stp[i] = -1;
					ext[i] = -1;
					nxt[i] = sat_u32(((relv - cx * del) << 16) / mag);
				end else begin
					mag = dv;
					face = (cx + 1) * del;
					stp[i] = 1;
					ext[i] = sz - 1;
					nxt[i] = face > relv ? sat_u32(((face - relv) << 16) / mag) : 0;
				end
				inc[i] = sat_u32((del << 16) / mag);
			end
		end
		n = 0;
		done = 0;
		while (!done) begin
			if (nxt[0] < nxt[1] && nxt[0] < nxt[2])
				ax = 0;
			else if (nxt[1] < nxt[2])
				ax = 1;
			else
				ax = 2;
			t = nxt[ax];
			v.cx = idx[0][3:0];
			v.cy = idx[1][3:0];
			v.cz = idx[2][3:0];
			v.axis = ax[1:0];
			v.exit_t = t > vw3_pkg::EXIT_SAT ? vw3_pkg::EXIT_SAT : t[30:0];
			n++;
			idx[ax] += stp[ax];
			if (stp[ax] > 0)
				leave = idx[ax] >= ext[ax];
			else if (stp[ax] < 0)
				leave = idx[ax] < 0;
			else
				leave = 0;
			if (t > r.maxd || leave || n >= vw3_pkg::MAX_RESULTS) begin
				done = 1;
				v.fin = 1'b1;
			end else begin
				v.fin = 1'b0;
				nxt[ax] = sat_u32(t + inc[ax]);
			end
			voxel_q.push_back(v);
		end
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx <= vw3_pkg::REG_SIZE_Z)
			grid_size[idx] = val[4:0];
		else
			voxel_edge[idx - vw3_pkg::REG_DELTA_X] = val[30:0];
	endtask

	task automatic drain();
		wait (voxel_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_ray(ray_req_t r, bit known, voxel_t want);
		@(negedge clk);
		in_valid = 1'b1;
		{rel_x, rel_y, rel_z} = {r.rel[0], r.rel[1], r.rel[2]};
		{dir_x, dir_y, dir_z} = {r.dir[0], r.dir[1], r.dir[2]};
		max_dist = r.maxd;
		do @(posedge clk); while (!in_ready);
		if (known)
			voxel_q.push_back(want);
		else
			trace_ray(r);
		if (--burst_left <= 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	function automatic ray_req_t make_ray();
		ray_req_t r;
		longint unsigned span;
		logic [31:0] d;
		for (int i = 0; i < 3; i++) begin
			span = (voxel_edge[i] == 0 ? 1 : voxel_edge[i]) * 64'(grid_size[i]);
			if (span > 64'h7FFF_FFFF)
				span = 64'h7FFF_FFFF;
			r.rel[i] = ($urandom_range(0, 4) == 0) ? 31'($urandom) :
				31'($urandom_range(0, 32'(span)));
			case ($urandom_range(0, 9))
				0: d = '0;
				1: d = $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
					($urandom_range(0, 2) == 0 ? 32'h7FFF_FFFF :
					($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF));
				2: d = $urandom;
				default: begin
					d = $urandom_range(1, 32'h0004_0000);
					if ($urandom_range(0, 1))
						d = -d;
				end
			endcase
			r.dir[i] = d;
		end
		r.maxd = ($urandom_range(0, 9) < 7) ? 31'h7FFF_FFFF : 31'($urandom);
		return r;
	endfunction

	always @(negedge clk) begin
		rx_cyc++;
		case (rx_cyc[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= $urandom_range(0, 1);
			2'd2: out_ready <= (rx_cyc[2:0] == 3'd0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		voxel_t got, exp_v;
		if (out_valid && out_ready) begin
			got = {cell_x, cell_y, cell_z, stepped_axis, exit_param, last};
			if (voxel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected voxel %p", got);
			end else begin
				exp_v = voxel_q.pop_front();
				if (got !== exp_v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("voxel mismatch: expected %p, got %p", exp_v, got);
				end
			end
		end
		if ((out_valid && out_ready) || (in_valid && in_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("voxel_walk_3d_dda: mismatch");
			$finish;
		end
	end

	function automatic void add_row(logic [30:0] rl, logic [31:0] dx, logic [31:0] dy,
		logic [31:0] dz, logic [30:0] md, logic known, voxel_t want);
		ray_row_t row;
		row.ray.rel = {rl, rl, rl};
		row.ray.dir = {dz, dy, dx};
		row.ray.maxd = md;
		row.known = known;
		row.want = want;
		rows.push_back(row);
	endfunction

	initial begin
		localparam logic [30:0] MAXV = 31'h7FFF_FFFF;
		localparam logic [31:0] ONE = 32'h0001_0000;
		ray_req_t r;
		voxel_t none;
		none = '0;
		grid_size = {vw3_pkg::SIZE_RST, vw3_pkg::SIZE_RST, vw3_pkg::SIZE_RST};
		voxel_edge = {vw3_pkg::DELTA_RST, vw3_pkg::DELTA_RST, vw3_pkg::DELTA_RST};
		add_row(0, 0, 0, 0, MAXV, 1,
			'{4'd0, 4'd0, 4'd0, vw3_pkg::AXIS_Z, vw3_pkg::EXIT_SAT, 1'b1});
		add_row(MAXV, 0, 0, 0, MAXV, 1,
			'{4'd15, 4'd15, 4'd15, vw3_pkg::AXIS_Z, vw3_pkg::EXIT_SAT, 1'b1});
		add_row(0, 0, 0, 0, 0, 1,
			'{4'd0, 4'd0, 4'd0, vw3_pkg::AXIS_Z, vw3_pkg::EXIT_SAT, 1'b1});
		add_row(31'd100, ONE, 0, 0, MAXV, 0, none);
		add_row(31'd70000, -ONE, 0, 0, MAXV, 0, none);
		add_row(31'd4000, 0, ONE, 0, MAXV, 0, none);
		add_row(31'd90000, 0, 0, -ONE, MAXV, 0, none);
		add_row(31'd1234, ONE, 32'h0002_3000, 32'h0000_8000, MAXV, 0, none);
		add_row(31'd5000, 32'h7FFF_FFFF, 32'h8000_0000, ONE, MAXV, 0, none);
		add_row(31'd5000, ONE, ONE, ONE, 0, 0, none);
		add_row(31'd5000, 32'd1, 32'hFFFF_FFFF, 0, MAXV, 0, none);
		add_row(MAXV, ONE, 32'h0000_C000, 0, MAXV, 0, none);
		add_row(MAXV, -ONE, -ONE, -ONE, MAXV, 0, none);
		add_row(31'd0, ONE, ONE, ONE, 31'h0003_0000, 0, none);
		add_row(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, MAXV, 0, none);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[k])
			send_ray(rows[k].ray, rows[k].known, rows[k].want);
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				drain();
				case (ph)
					1: begin
						reg_write(vw3_pkg::REG_SIZE_X, 2);
						reg_write(vw3_pkg::REG_SIZE_Y, 2);
						reg_write(vw3_pkg::REG_SIZE_Z, 2);
						reg_write(vw3_pkg::REG_DELTA_X, 32'h0001_0000);
						reg_write(vw3_pkg::REG_DELTA_Y, 32'h0001_0000);
						reg_write(vw3_pkg::REG_DELTA_Z, 32'h0001_0000);
					end
					2: begin
						reg_write(vw3_pkg::REG_SIZE_X, 31);
						reg_write(vw3_pkg::REG_SIZE_Y, 0);
						reg_write(vw3_pkg::REG_SIZE_Z, 1);
						reg_write(vw3_pkg::REG_DELTA_X, 0);
						reg_write(vw3_pkg::REG_DELTA_Y, 32'h7FFF_FFFF);
						reg_write(vw3_pkg::REG_DELTA_Z, 1);
					end
					3: begin
						reg_write(vw3_pkg::REG_SIZE_X, 16);
						reg_write(vw3_pkg::REG_SIZE_Y, 9);
						reg_write(vw3_pkg::REG_SIZE_Z, 5);
						reg_write(vw3_pkg::REG_DELTA_X, $urandom_range(1, 32'h0004_0000));
						reg_write(vw3_pkg::REG_DELTA_Y, $urandom_range(1, 32'h0004_0000));
						reg_write(vw3_pkg::REG_DELTA_Z, $urandom);
					end
					default: begin
						for (int i = 0; i < 3; i++)
							reg_write(3'(vw3_pkg::REG_SIZE_X + i), $urandom_range(0, 31));
						for (int i = 0; i < 3; i++)
							reg_write(3'(vw3_pkg::REG_DELTA_X + i),
								$urandom_range(1, 32'h0002_0000));
					end
				endcase
			end
			for (int k = 0; k < 100; k++) begin
				if (ph == 2 && k == 50) begin
					@(negedge clk);
					in_valid = 1'b0;
					wait (voxel_q.size() == 0);
				end
				r = make_ray();
				send_ray(r, 0, none);
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
		wait (voxel_q.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("voxel_walk_3d_dda: match");
		else
			$display("voxel_walk_3d_dda: mismatch");
		$finish;
	end
endmodule

[voxel_walk_3d_dda.f]
sv/vw3_pkg.sv
sv/vw3_front.sv
sv/vw3_div.sv
sv/vw3_back.sv
sv/voxel_walk_3d_dda.sv
verif/tb_top.sv
